>>> rtl/dgl_pkg.sv
// ----------------------------------------------------------------------------
// dgl_pkg
// Types, constants and table functions shared by the date gap charge block.
// ----------------------------------------------------------------------------
package dgl_pkg;

    localparam int TEXT_W   = 64;
    localparam int NUM_W    = 22;
    localparam int GAP_W    = 23;
    localparam int CHARGE_W = 12;
    localparam int YEAR_W   = 14;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    localparam logic [CHARGE_W-1:0] CHARGE_CAP = 12'd2500;
    localparam logic [CHARGE_W-1:0] TIER2_BASE = 12'd150;
    localparam logic [CHARGE_W-1:0] TIER1_RATE = 12'd5;
    localparam logic [CHARGE_W-1:0] TIER2_RATE = 12'd7;
    localparam logic [CHARGE_W-1:0] TIER1_FROM = 12'd30;
    localparam logic [CHARGE_W-1:0] TIER2_FROM = 12'd60;

    typedef struct packed {
        logic [TEXT_W-1:0] start_text;
        logic [TEXT_W-1:0] end_text;
    } req_t;

    typedef struct packed {
        logic signed [GAP_W-1:0] day_gap;
        logic [CHARGE_W-1:0]     charge_tenths;
        logic                    invalid;
    } res_t;

    typedef struct packed {
        logic [YEAR_W-1:0] year;
        logic [NUM_W-1:0]  day_num;
        logic              ok;
    } date_info_t;

    function automatic logic [4:0] month_length(input logic [6:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
            7'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [6:0] month);
        logic [8:0] days;
        unique case (month)
            7'd1:    days = 9'd0;
            7'd2:    days = 9'd31;
            7'd3:    days = 9'd59;
            7'd4:    days = 9'd90;
            7'd5:    days = 9'd120;
            7'd6:    days = 9'd151;
            7'd7:    days = 9'd181;
            7'd8:    days = 9'd212;
            7'd9:    days = 9'd243;
            7'd10:   days = 9'd273;
            7'd11:   days = 9'd304;
            7'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> rtl/dgl_date_unit.sv
// ----------------------------------------------------------------------------
// dgl_date_unit
// Two-stage decoder: ASCII digits to fields, then fields to a day number.
// ----------------------------------------------------------------------------
module dgl_date_unit (
    input  logic                          clk,
    input  logic [dgl_pkg::TEXT_W-1:0]    text,
    output dgl_pkg::date_info_t           info
);

    logic [3:0] digit [8];
    logic [7:0] digit_ok;

    logic [6:0] cent_next,  cent_reg;
    logic [6:0] rem_next,   rem_reg;
    logic [6:0] month_next, month_reg;
    logic [6:0] day_next,   day_reg;
    logic       chars_ok_next, chars_ok_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digit_ok[i] = (text[63-8*i -: 8] >= dgl_pkg::ASCII_ZERO) &&
                          (text[63-8*i -: 8] <= dgl_pkg::ASCII_NINE);
            digit[i]    = digit_ok[i] ? text[63-8*i-4 -: 4] : 4'd0;
        end
        cent_next     = 7'(digit[0]) * 7'd10 + 7'(digit[1]);
        rem_next      = 7'(digit[2]) * 7'd10 + 7'(digit[3]);
        month_next    = 7'(digit[4]) * 7'd10 + 7'(digit[5]);
        day_next      = 7'(digit[6]) * 7'd10 + 7'(digit[7]);
        chars_ok_next = &digit_ok;
    end

    always_ff @(posedge clk)
    begin
        cent_reg     <= cent_next;
        rem_reg      <= rem_next;
        month_reg    <= month_next;
        day_reg      <= day_next;
        chars_ok_reg <= chars_ok_next;
    end

    logic [dgl_pkg::YEAR_W-1:0] year;
    logic                       rem_zero;
    logic                       leap;
    logic [4:0]                 mlen;
    logic                       fields_ok;
    logic [dgl_pkg::NUM_W-1:0]  year_days;
    logic [dgl_pkg::NUM_W-1:0]  quad_days;
    logic [dgl_pkg::NUM_W-1:0]  cent_days;
    logic [dgl_pkg::NUM_W-1:0]  quad_cent_days;
    logic [dgl_pkg::NUM_W-1:0]  in_year_days;
    dgl_pkg::date_info_t        info_next, info_reg;

    always_comb
    begin
        year      = 14'(cent_reg) * 14'd100 + 14'(rem_reg);
        rem_zero  = (rem_reg == 7'd0);
        leap      = rem_zero ? (cent_reg[1:0] == 2'd0) : (rem_reg[1:0] == 2'd0);
        mlen      = dgl_pkg::month_length(month_reg, leap);
        fields_ok = (month_reg >= 7'd1) && (month_reg <= 7'd12) &&
                    (day_reg >= 7'd1) && (day_reg <= {2'b00, mlen});

        year_days      = 22'(year) * 22'd365;
        quad_days      = 22'((15'(year) + 15'd3) >> 2);
        cent_days      = 22'(cent_reg) + 22'(!rem_zero);
        quad_cent_days = rem_zero ? 22'((8'(cent_reg) + 8'd3) >> 2)
                                  : 22'(cent_reg >> 2) + 22'd1;
        in_year_days   = 22'(dgl_pkg::days_before_month(month_reg))
                       + 22'(leap && (month_reg > 7'd2))
                       + 22'(day_reg) - 22'd1;

        info_next.year    = year;
        info_next.day_num = year_days + quad_days - cent_days + quad_cent_days + in_year_days;
        info_next.ok      = chars_ok_reg && fields_ok;
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    assign info = info_reg;

endmodule

>>> rtl/dgl_charge.sv
// ----------------------------------------------------------------------------
// dgl_charge
// Tiered charge from the day gap, with the registered result word.
// ----------------------------------------------------------------------------
module dgl_charge (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              gap_valid,
    input  logic signed [dgl_pkg::GAP_W-1:0]  gap,
    input  logic                              gap_invalid,
    output logic                              done,
    output dgl_pkg::res_t                     result
);

    logic [dgl_pkg::CHARGE_W-1:0] low;
    logic [dgl_pkg::CHARGE_W-1:0] charge;
    dgl_pkg::res_t                result_next, result_reg;
    logic                         done_reg;

    always_comb
    begin
        low = {4'b0000, gap[7:0]};
        if (gap < 23'sd31)
            charge = '0;
        else if (gap > 23'sd180)
            charge = dgl_pkg::CHARGE_CAP;
        else if (gap < 23'sd61)
            charge = 12'((low - dgl_pkg::TIER1_FROM) * dgl_pkg::TIER1_RATE);
        else
            charge = dgl_pkg::TIER2_BASE
                   + 12'((low - dgl_pkg::TIER2_FROM) * dgl_pkg::TIER2_RATE);

        if (gap_invalid)
        begin
            result_next.day_gap       = '0;
            result_next.charge_tenths = '0;
            result_next.invalid       = 1'b1;
        end
        else
        begin
            result_next.day_gap       = gap;
            result_next.charge_tenths = charge;
            result_next.invalid       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= gap_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/date_gap_late_charge.sv
// ----------------------------------------------------------------------------
// date_gap_late_charge
// Day gap between two ASCII dates and the tiered late charge it implies.
//
//   channel  | handshake          | word
//   ---------+--------------------+--------------------------------------
//   request  | start, busy        | start_text, end_text (YYYYMMDD ASCII)
//   result   | done (one cycle)   | day_gap, charge_tenths, invalid
//
// Four register stages: digit decode, day number, gap, charge. One word
// per cycle sustained. busy is always low, so a word may enter on every
// cycle. rst_n clears only the stage valid bits. The receiver takes every
// result; nothing stalls.
// ----------------------------------------------------------------------------
module date_gap_late_charge (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  dgl_pkg::req_t   request,
    output logic            busy,
    output logic            done,
    output dgl_pkg::res_t   result
);

    dgl_pkg::date_info_t first_info;
    dgl_pkg::date_info_t second_info;

    logic v1_reg, v2_reg, v3_reg;
    logic signed [dgl_pkg::GAP_W-1:0] gap_next, gap_reg;
    logic                             inv_next, inv_reg;

    assign busy = 1'b0;

    dgl_date_unit u_first (
        .clk  (clk),
        .text (request.start_text),
        .info (first_info)
    );

    dgl_date_unit u_second (
        .clk  (clk),
        .text (request.end_text),
        .info (second_info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_comb
    begin
        gap_next = $signed({1'b0, second_info.day_num}) - $signed({1'b0, first_info.day_num});
        inv_next = !first_info.ok || !second_info.ok || (second_info.year < first_info.year);
    end

    always_ff @(posedge clk)
    begin
        gap_reg <= gap_next;
        inv_reg <= inv_next;
    end

    dgl_charge u_charge (
        .clk         (clk),
        .rst_n       (rst_n),
        .gap_valid   (v3_reg),
        .gap         (gap_reg),
        .gap_invalid (inv_reg),
        .done        (done),
        .result      (result)
    );

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.invalid |-> (result.day_gap == '0) && (result.charge_tenths == '0))
        else $error("invalid result carries nonzero fields");

    a_charge_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.charge_tenths <= dgl_pkg::CHARGE_CAP)
        else $error("charge above cap");

    a_charge_needs_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.charge_tenths != '0) |-> !result.invalid && (result.day_gap > 23'sd30))
        else $error("charge without a long enough gap");

    a_done_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |=> done)
        else $error("gap stage word lost before output");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the date gap late charge block. Request words are predicted
// as they are accepted: both ASCII dates are decoded, the Gregorian day
// numbers are computed and the tiered charge derived. Every done cycle
// is compared against the oldest prediction. A directed set covers leap
// rules, tier edges and malformed dates. Random words then follow, mostly
// valid date pairs a short distance apart, with some corrupted and some
// pure noise. Idle bursts are inserted at random on the request side before item CALM_FROM.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ITEMS     = 1400;
    localparam int CALM_FROM = 1200;
    localparam int LIMIT     = 200000;

    class late_charge_sb;
        dgl_pkg::res_t charge_due[$];
        int unsigned   errors;

        static function bit leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int unsigned mdays(int unsigned y, int unsigned m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        function void parse_date(input logic [dgl_pkg::TEXT_W-1:0] t,
                                 output int unsigned y,
                                 output int unsigned m, output int unsigned d,
                                 output bit ok);
            int unsigned dig[8];
            logic [7:0]  ch;
            ok = 1'b1;
            for (int i = 0; i < 8; i++)
            begin
                ch = t[dgl_pkg::TEXT_W-1-8*i -: 8];
                if (ch < dgl_pkg::ASCII_ZERO || ch > dgl_pkg::ASCII_NINE)
                begin
                    ok = 1'b0;
                    dig[i] = 0;
                end
                else
                begin
                    dig[i] = ch - dgl_pkg::ASCII_ZERO;
                end
            end
            y = dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3];
            m = dig[4] * 10 + dig[5];
            d = dig[6] * 10 + dig[7];
            if (m < 1 || m > 12)
                ok = 1'b0;
            else if (d < 1 || d > mdays(y, m))
                ok = 1'b0;
        endfunction

        function int unsigned day_count(int unsigned y, int unsigned m, int unsigned d);
            int unsigned n;
            n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
            for (int unsigned mm = 1; mm < m; mm++)
                n += mdays(y, mm);
            return n + d - 1;
        endfunction

        function dgl_pkg::res_t predict_charge(dgl_pkg::req_t r);
            int unsigned   ya, ma, da, yb, mb, db;
            bit            oka, okb;
            int            gap;
            int            charge;
            dgl_pkg::res_t p;
            p = '0;
            parse_date(r.start_text, ya, ma, da, oka);
            parse_date(r.end_text, yb, mb, db, okb);
            if (!oka || !okb || yb < ya)
            begin
                p.invalid = 1'b1;
                return p;
            end
            gap = int'(day_count(yb, mb, db)) - int'(day_count(ya, ma, da));
            if (gap < 31)
                charge = 0;
            else if (gap > 180)
                charge = 2500;
            else if (gap < 61)
                charge = (gap - 30) * 5;
            else
                charge = 150 + (gap - 60) * 7;
            p.day_gap       = gap[dgl_pkg::GAP_W-1:0];
            p.charge_tenths = charge[dgl_pkg::CHARGE_W-1:0];
            return p;
        endfunction

        function void note_request(dgl_pkg::req_t r);
            charge_due.push_back(predict_charge(r));
        endfunction

        function void check_result(dgl_pkg::res_t got);
            dgl_pkg::res_t exp;
            if (charge_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result gap %0d charge %0d invalid %0b",
                         $time, got.day_gap, got.charge_tenths, got.invalid);
                return;
            end
            exp = charge_due.pop_front();
            if (got.day_gap !== exp.day_gap || got.charge_tenths !== exp.charge_tenths ||
                got.invalid !== exp.invalid)
            begin
                errors++;
                $display("%0t: mismatch expected gap %0d charge %0d invalid %0b,",
                         $time, exp.day_gap, exp.charge_tenths, exp.invalid,
                         " got gap %0d charge %0d invalid %0b",
                         got.day_gap, got.charge_tenths, got.invalid);
            end
        endfunction

        function int pending();
            return charge_due.size();
        endfunction
    endclass

    logic          clk     = 1'b0;
    logic          rst_n   = 1'b0;
    logic          start   = 1'b0;
    dgl_pkg::req_t request = '0;
    logic          busy;
    logic          done;
    dgl_pkg::res_t result;
    int unsigned   cycles = 0;

    late_charge_sb sb = new();

    date_gap_late_charge u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
        if (rst_n && start && !busy)
            sb.note_request(request);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [dgl_pkg::TEXT_W-1:0] date_text(int unsigned y, int unsigned m,
                                                              int unsigned d);
        logic [dgl_pkg::TEXT_W-1:0] t;
        int unsigned                n;
        n = y * 10000 + m * 100 + d;
        for (int i = 0; i < 8; i++)
        begin
            t[8*i +: 8] = dgl_pkg::ASCII_ZERO + 8'(n % 10);
            n = n / 10;
        end
        return t;
    endfunction

    task automatic rand_date(output int unsigned y, output int unsigned m,
                             output int unsigned d, input int unsigned ylo,
                             input int unsigned yhi);
        if ($urandom_range(0, 9) == 0)
            y = $urandom_range(ylo / 100, yhi / 100) * 100;
        else
            y = $urandom_range(ylo, yhi);
        if (y < ylo)
            y = ylo;
        m = $urandom_range(1, 12);
        d = $urandom_range(1, late_charge_sb::mdays(y, m));
    endtask

    task automatic step_days(inout int unsigned y, inout int unsigned m,
                             inout int unsigned d, input int unsigned k);
        repeat (k)
        begin
            d++;
            if (d > late_charge_sb::mdays(y, m))
            begin
                d = 1;
                m++;
                if (m > 12)
                begin
                    m = 1;
                    y++;
                end
            end
        end
    endtask

    task automatic make_item(output dgl_pkg::req_t r);
        int unsigned ya, ma, da, yb, mb, db;
        int unsigned kind;
        int unsigned pos;
        kind = $urandom_range(0, 99);
        rand_date(ya, ma, da, 0, 9990);
        yb = ya;
        mb = ma;
        db = da;
        if (kind < 50)
        begin
            if ($urandom_range(0, 4) == 0)
                step_days(yb, mb, db, $urandom_range(0, 1000));
            else
                step_days(yb, mb, db, $urandom_range(0, 200));
        end
        else if (kind < 60)
        begin
            mb = $urandom_range(1, 12);
            db = $urandom_range(1, late_charge_sb::mdays(yb, mb));
        end
        else if (kind < 78)
        begin
            rand_date(yb, mb, db, (kind < 70) ? ya : 0, 9999);
        end
        r.start_text = date_text(ya, ma, da);
        r.end_text   = date_text(yb, mb, db);
        if (kind >= 78 && kind < 88)
        begin
            pos = $urandom_range(0, 7);
            if ($urandom_range(0, 1))
                r.start_text[dgl_pkg::TEXT_W-1-8*pos -: 8] = 8'($urandom_range(0, 255));
            else
                r.end_text[dgl_pkg::TEXT_W-1-8*pos -: 8] = 8'($urandom_range(0, 255));
        end
        else if (kind >= 88 && kind < 94)
        begin
            if ($urandom_range(0, 1))
                r.start_text = date_text(ya, $urandom_range(0, 99), $urandom_range(0, 99));
            else
                r.end_text = date_text(yb, $urandom_range(0, 99), $urandom_range(0, 99));
        end
        else if (kind >= 94)
        begin
            r.start_text = {$urandom, $urandom};
            r.end_text   = {$urandom, $urandom};
        end
    endtask

    task automatic send(logic [dgl_pkg::TEXT_W-1:0] a, logic [dgl_pkg::TEXT_W-1:0] b);
        start              <= 1'b1;
        request.start_text <= a;
        request.end_text   <= b;
        @(negedge clk);
        while (busy)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic idle(int unsigned n);
        start   <= 1'b0;
        request <= {$urandom, $urandom, $urandom, $urandom};
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        dgl_pkg::req_t r;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send("00000101", "99991231");
        send("00000229", "00000301");
        send("19000101", "19000229");
        send("20000229", "20000229");
        send("21000228", "21000229");
        send("20241231", "20240101");
        send("20230101", "20230131");
        send("20230101", "20230201");
        send("20230101", "20230302");
        send("20230101", "20230303");
        send("20230101", "20230630");
        send("20230101", "20230701");
        send("20231231", "20240101");
        send("20240101", "20231231");
        send("20230001", "20230101");
        send("20231301", "20231301");
        send("20230100", "20230101");
        send("20230101", "20230132");
        send("20230101", "20230431");
        send("2023/101", "20230101");
        send("20230101", "2023010:");
        send(64'h0, 64'h0);
        send({dgl_pkg::TEXT_W{1'b1}}, {dgl_pkg::TEXT_W{1'b1}});
        wait_drain();

        for (int i = 0; i < ITEMS; i++)
        begin
            if (i < CALM_FROM && $urandom_range(0, 3) == 0)
                idle($urandom_range(1, 5));
            if (i == ITEMS / 2)
                wait_drain();
            make_item(r);
            send(r.start_text, r.end_text);
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> files.f
rtl/dgl_pkg.sv
rtl/dgl_date_unit.sv
rtl/dgl_charge.sv
rtl/date_gap_late_charge.sv
tb/tb_top.sv
